// ===== rtl/core/hbm_pkg.sv =====
// shared types, constants and hash functions for the hashed bucket map
package hbm_pkg;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FOUND    = 2'd1;
	localparam logic [1:0] ST_MISSING  = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_FILL,
		S_WALK,
		S_CHECK
	} hbm_state_t;

	// one byte step of the running hash
	function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t;
		t = h + {{24{b[7]}}, b};
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	// final avalanche of the hash
	function automatic logic [31:0] finish_hash(input logic [31:0] h);
		logic [31:0] t;
		t = h + (h << 3);
		t = t ^ (t >> 11);
		t = t + (t << 15);
		return t;
	endfunction

endpackage

// ===== rtl/core/hashed_bucket_map_top.sv =====
// top level of the hashed bucket map
// Key bytes are taken with start while busy is low; a byte that is not the
// last is folded into the running hash. On the last byte the bucket index is
// found by a bit-serial remainder and the bucket fill count is read from its
// memory; an insert, or a lookup of an empty bucket, then raises done, and
// busy drops in that same cycle. A lookup of a non-empty bucket instead reads
// the bucket's entries from the entry memories in turn, comparing stored
// hashes, until a match or the last filled entry, and then raises done.
// The result appears for one cycle with done high and cannot be stalled.
// After reset a clearing pass zeroes the fill memory; busy stays high
// meanwhile.
module hashed_bucket_map_top
	import hbm_pkg::*;
#(
	parameter int MAX_BUCKETS      = 256,
	parameter int SLOTS_PER_BUCKET = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_value,
	output logic [31:0] key_hash,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int FW  = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int EW  = BW + SW;
	localparam int DW  = $clog2(MAX_BUCKETS + 1) > 9 ? $clog2(MAX_BUCKETS + 1) : 9;
	localparam logic [2:0] REG_BUCKET_COUNT = 3'd0;

	hbm_state_t state_q, state_d;

	logic [8:0]    bucket_count_q;
	logic [31:0]   run_hash_q;
	logic [31:0]   hash_q;
	logic          func_q;
	logic [31:0]   value_q;
	logic [BW-1:0] bucket_q;
	logic [FW-1:0] fill_q;
	logic [SW:0]   idx_q;
	logic          clr_q;
	logic [BW:0]   clr_cnt_q;
	logic [5:0]    div_cnt_q;
	logic          accept;
	logic [DW-1:0] divisor;
	logic [DW-1:0] rem;
	logic          mod_go;
	logic          mod_done_unused;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_BUCKET_COUNT) ? {23'd0, bucket_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= 9'd256;
		end else if (psel && penable && pwrite && paddr == REG_BUCKET_COUNT) begin
			bucket_count_q <= pwdata[8:0];
		end
	end

	// clamp bucket count into 1..MAX_BUCKETS
	always_comb begin
		if (bucket_count_q == 9'd0) begin
			divisor = DW'(1);
		end else if (DW'(bucket_count_q) > DW'(MAX_BUCKETS)) begin
			divisor = DW'(MAX_BUCKETS);
		end else begin
			divisor = DW'(bucket_count_q);
		end
	end

	assign busy   = (state_q != S_IDLE) || clr_q;
	assign accept = start && !busy;
	assign mod_go = accept && key_last;

	hbm_mod #(.DW(DW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (finish_hash(mix_byte(run_hash_q, key_byte))),
		.divisor  (divisor),
		.done     (mod_done_unused),
		.rem      (rem)
	);

	// memories
	logic          fill_we;
	logic [BW-1:0] fill_waddr;
	logic [FW-1:0] fill_wdata;
	logic [FW-1:0] fill_rdata;
	logic          ent_we;
	logic [EW-1:0] ent_waddr;
	logic [EW-1:0] ent_raddr;
	logic [31:0]   ent_hash_rdata;
	logic [31:0]   ent_val_rdata;
	logic [BW-1:0] bucket_now;

	assign bucket_now = BW'(rem);

	hbm_ram #(.WIDTH(FW), .DEPTH(1 << BW)) u_fill (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (bucket_now),
		.rdata (fill_rdata)
	);

	hbm_ram #(.WIDTH(32), .DEPTH(1 << EW)) u_ent_hash (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (hash_q),
		.raddr (ent_raddr),
		.rdata (ent_hash_rdata)
	);

	hbm_ram #(.WIDTH(32), .DEPTH(1 << EW)) u_ent_val (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (value_q),
		.raddr (ent_raddr),
		.rdata (ent_val_rdata)
	);

	logic fill_full;
	assign fill_full = (fill_q >= FW'(SLOTS_PER_BUCKET));
	assign ent_raddr = {bucket_q, idx_q[SW-1:0]};
	assign ent_waddr = {bucket_q, fill_q[SW-1:0]};
	assign ent_we    = (state_q == S_FILL) && (func_q == FUNC_INSERT) && !fill_full;

	// fill write: clearing pass or insert
	always_comb begin
		if (clr_q) begin
			fill_we    = 1'b1;
			fill_waddr = clr_cnt_q[BW-1:0];
			fill_wdata = '0;
		end else begin
			fill_we    = ent_we;
			fill_waddr = bucket_q;
			fill_wdata = fill_q + FW'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (mod_go) state_d = S_DIV;
			S_DIV:   if (div_cnt_q == 6'd33) state_d = S_FILL;
			S_FILL:  if (func_q == FUNC_INSERT || fill_q == '0) state_d = S_IDLE;
				else state_d = S_WALK;
			S_WALK:  state_d = S_CHECK;
			S_CHECK: if (ent_hash_rdata == hash_q || (idx_q + 1'b1) >= (SW+1)'(fill_q))
					state_d = S_IDLE;
				else state_d = S_WALK;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			run_hash_q <= '0;
			clr_q      <= 1'b1;
			clr_cnt_q  <= '0;
			div_cnt_q  <= '0;
			done       <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (BW+1)'((1 << BW) - 1)) clr_q <= 1'b0;
			end
			if (accept) begin
				run_hash_q <= key_last ? 32'd0 : mix_byte(run_hash_q, key_byte);
			end
			if (state_q == S_DIV) div_cnt_q <= div_cnt_q + 6'd1;
			else div_cnt_q <= '0;
			if (state_q == S_FILL && state_d == S_IDLE) done <= 1'b1;
			if (state_q == S_CHECK && state_d == S_IDLE) done <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mod_go) begin
			hash_q  <= finish_hash(mix_byte(run_hash_q, key_byte));
			func_q  <= func;
			value_q <= value;
		end
		// remainder settles after all dividend bits, fill read arrives the cycle after
		if (state_q == S_DIV && div_cnt_q == 6'd32) bucket_q <= bucket_now;
		if (state_q == S_DIV && div_cnt_q == 6'd33) begin
			fill_q <= (fill_rdata > FW'(SLOTS_PER_BUCKET)) ? FW'(SLOTS_PER_BUCKET) : fill_rdata;
			idx_q  <= '0;
		end
		if (state_q == S_CHECK) idx_q <= idx_q + 1'b1;
		// result
		if (state_q == S_FILL) begin
			key_hash    <= hash_q;
			found_value <= 32'd0;
			if (func_q == FUNC_INSERT) status <= fill_full ? ST_FULL : ST_INSERTED;
			else status <= ST_MISSING;
		end
		if (state_q == S_CHECK && ent_hash_rdata == hash_q) begin
			status      <= ST_FOUND;
			found_value <= ent_val_rdata;
		end
	end

endmodule

// ===== rtl/core/hbm_ram.sv =====
// generic single-port-write, registered-read memory
module hbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/hbm_mod.sv =====
// restoring remainder unit, one quotient bit per cycle
module hbm_mod
	import hbm_pkg::*;
#(
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [31:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] rem
);

	logic [DW:0]   rem_q;
	logic [31:0]   dvd_q;
	logic [5:0]    cnt_q;
	logic          run_q;
	logic [DW:0]   trial;
	logic [DW+1:0] shifted;

	// shift in next dividend bit and conditionally subtract
	always_comb begin
		shifted = {rem_q, dvd_q[31]};
		trial   = shifted[DW:0] - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 6'd0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			if (shifted >= {1'b0, divisor}) begin
				rem_q <= trial;
			end else begin
				rem_q <= shifted[DW:0];
			end
		end
	end

	assign done = run_q && (cnt_q == 6'd31);
	assign rem  = rem_q[DW-1:0];

endmodule
